[rtl/bmm_pkg.sv]
// shared types, codes and constants of the banked memory mapper
package bmm_pkg;

  // transaction kinds
  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_FETCH  = 2'd2,
    KIND_LOOKUP = 2'd3
  } kind_e;

  // access targets
  typedef enum logic [1:0] {
    TGT_FLASH   = 2'd0,
    TGT_RAM     = 2'd1,
    TGT_NONE    = 2'd2,
    TGT_BLOCKED = 2'd3
  } target_e;

  // fetch fault codes
  typedef enum logic [1:0] {
    FLT_NONE  = 2'd0,
    FLT_FLASH = 2'd1,
    FLT_RAM   = 2'd2
  } fault_e;

  // register indexes
  localparam logic [2:0] REG_PAGE_MAP     = 3'd0;
  localparam logic [2:0] REG_TOP_WIN      = 3'd1;
  localparam logic [2:0] REG_BOT_WIN      = 3'd2;
  localparam logic [2:0] REG_FLASH_EXEC   = 3'd3;
  localparam logic [2:0] REG_RAM_MASK     = 3'd4;
  localparam logic [2:0] REG_RAM_BOUNDS   = 3'd5;
  localparam logic [2:0] REG_DELAYS       = 3'd6;
  localparam logic [2:0] REG_FLASH_UNLOCK = 3'd7;

  localparam int unsigned ADDR_W  = 22;
  localparam int unsigned PADDR_W = 6;
  localparam int unsigned PDATA_W = 64;

  // address map
  localparam logic [21:0] FLASH_END    = 22'h200000;
  localparam logic [21:0] RAM_END      = 22'h220000;
  localparam logic [21:0] SECTOR_START = 22'h1F0000;
  localparam logic [7:0]  LOCKED_PAGE  = 8'h7E;
  localparam logic [7:0]  TOP_PAGE     = 8'h80;
  localparam logic [7:0]  BOTTOM_PAGE  = 8'h81;
  localparam logic [15:0] UPPER_HALF   = 16'h8000;
  localparam logic [15:0] LOGICAL_TOP  = 16'hFFFF;
  localparam logic [14:0] PAGE_SIZE    = 15'h4000;
  localparam logic [15:0] RESET_VECTOR = 16'h0038;
  localparam logic [21:0] RAM_MASK_RST = 22'h3FFFFF;
  localparam logic [7:0]  EMPTY_BYTE   = 8'hFF;

  // unlock detector states
  localparam logic [2:0] UNLOCK_ARMED = 3'd6;
  localparam logic [2:0] UNLOCK_DONE  = 3'd7;

  typedef struct packed {
    logic [31:0] page_map;
    logic [5:0]  top_win;
    logic [5:0]  bot_win;
    logic [15:0] flash_exec_range;
    logic [21:0] ram_exec_mask;
    logic [43:0] ram_exec_bounds;
    logic [47:0] access_delays;
    logic        flash_unlock;
  } cfg_t;

  typedef struct packed {
    logic [21:0] phys_addr;
    target_e     target;
    logic [7:0]  cycles_added;
    logic [7:0]  read_value;
    fault_e      restrict_fault;
    logic        no_os_fault;
    logic [15:0] logical_addr;
    logic        logical_valid;
    logic [2:0]  protect_state;
  } res_t;

  // expected byte for each step of the unlock sequence
  function automatic logic [7:0] unlock_byte(input logic [2:0] step);
    logic [7:0] b;
    case (step)
      3'd0: b = 8'h00;
      3'd1: b = 8'h00;
      3'd2: b = 8'hED;
      3'd3: b = 8'h56;
      3'd4: b = 8'hF3;
      3'd5: b = 8'hD3;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[rtl/banked_memory_mapper_with_exec_guard.sv]
// top level of the banked memory mapper with execute guard
// Takes one transaction per clock unless stalled and returns one result per transaction:
// the transaction is captured in an input register, translated by one stage of
// compare-and-select logic, and held in a result register until taken. Throughput is one
// transaction per cycle, set by that single translate stage; the unlock detector state is
// updated as each transaction moves into the result register, so consecutive transactions
// see each other's effect. Configuration lives behind an APB-style port with 64-bit data,
// register i at byte address 8*i; writes land on the access cycle and reads return the
// current value. Configuration should only be written while no transaction is in flight.
module banked_memory_mapper_with_exec_guard (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bmm_pkg::PADDR_W-1:0]   paddr,
  input  logic [bmm_pkg::PDATA_W-1:0]   pwdata,
  output logic [bmm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // transaction input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic [21:0]                   address_i,
  input  logic [7:0]                    data_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [21:0]                   phys_addr_o,
  output logic [1:0]                    target_o,
  output logic [7:0]                    cycles_added_o,
  output logic [7:0]                    read_value_o,
  output logic [1:0]                    restrict_fault_o,
  output logic                          no_os_fault_o,
  output logic [15:0]                   logical_addr_o,
  output logic                          logical_valid_o,
  output logic [2:0]                    protect_state_o
);
  import bmm_pkg::*;

  cfg_t        cfg;
  logic        s1_valid_q;
  kind_e       kind_q;
  logic [21:0] address_q;
  logic [7:0]  data_q;
  logic        out_valid_q;
  res_t        res_q;
  res_t        res_d;
  logic [2:0]  unlock_q;
  logic [2:0]  unlock_d;
  logic        adv;

  // configuration registers
  bmm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // translate stage
  bmm_xlate u_xlate (
    .kind_i    (kind_q),
    .address_i (address_q),
    .data_i    (data_q),
    .cfg_i     (cfg),
    .unlock_i  (unlock_q),
    .unlock_o  (unlock_d),
    .res_o     (res_d)
  );

  // pipeline flow control
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      unlock_q    <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (adv && s1_valid_q) begin
        unlock_q <= unlock_d;
      end
    end
  end

  // input and result payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q    <= kind_e'(kind_i);
      address_q <= address_i;
      data_q    <= data_i;
    end
    if (adv && s1_valid_q) begin
      res_q <= res_d;
    end
  end

  // result outputs
  assign out_valid_o      = out_valid_q;
  assign phys_addr_o      = res_q.phys_addr;
  assign target_o         = res_q.target;
  assign cycles_added_o   = res_q.cycles_added;
  assign read_value_o     = res_q.read_value;
  assign restrict_fault_o = res_q.restrict_fault;
  assign no_os_fault_o    = res_q.no_os_fault;
  assign logical_addr_o   = res_q.logical_addr;
  assign logical_valid_o  = res_q.logical_valid;
  assign protect_state_o  = res_q.protect_state;

`ifndef SYNTHESIS
  // detector state moves only when a transaction enters the result register
  a_unlock_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv && s1_valid_q) |=> $stable(unlock_q))
    else $error("unlock state changed without a transaction");

  // a blocked protected read or fetch returns the empty byte with cycles_added at zero
  a_blocked_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && target_o == TGT_BLOCKED) |-> (read_value_o == EMPTY_BYTE &&
    cycles_added_o == 8'd0))
    else $error("blocked read result malformed");

  // a successful reverse lookup never routes to memory
  a_lookup_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && logical_valid_o) |-> (target_o == TGT_NONE &&
    restrict_fault_o == FLT_NONE))
    else $error("lookup result carries an access target");

  // input stalls only when both stages are full and the output is stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled with room in the pipeline");
`endif

endmodule

[rtl/bmm_regs.sv]
// configuration register file with apb-style access
module bmm_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bmm_pkg::PADDR_W-1:0]   paddr,
  input  logic [bmm_pkg::PDATA_W-1:0]   pwdata,
  output logic [bmm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output bmm_pkg::cfg_t                 cfg_o
);
  import bmm_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[5:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // all zero except the ram execute mask, which resets to all ones
      cfg_q <= cfg_t'({32'd0, 6'd0, 6'd0, 16'd0, RAM_MASK_RST, 44'd0, 48'd0, 1'b0});
    end else if (wr_en) begin
      case (idx)
        REG_PAGE_MAP:     cfg_q.page_map         <= pwdata[31:0];
        REG_TOP_WIN:      cfg_q.top_win          <= pwdata[5:0];
        REG_BOT_WIN:      cfg_q.bot_win          <= pwdata[5:0];
        REG_FLASH_EXEC:   cfg_q.flash_exec_range <= pwdata[15:0];
        REG_RAM_MASK:     cfg_q.ram_exec_mask    <= pwdata[21:0];
        REG_RAM_BOUNDS:   cfg_q.ram_exec_bounds  <= pwdata[43:0];
        REG_DELAYS:       cfg_q.access_delays    <= pwdata[47:0];
        REG_FLASH_UNLOCK: cfg_q.flash_unlock     <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_PAGE_MAP:     prdata = {32'd0, cfg_q.page_map};
      REG_TOP_WIN:      prdata = {58'd0, cfg_q.top_win};
      REG_BOT_WIN:      prdata = {58'd0, cfg_q.bot_win};
      REG_FLASH_EXEC:   prdata = {48'd0, cfg_q.flash_exec_range};
      REG_RAM_MASK:     prdata = {42'd0, cfg_q.ram_exec_mask};
      REG_RAM_BOUNDS:   prdata = {20'd0, cfg_q.ram_exec_bounds};
      REG_DELAYS:       prdata = {16'd0, cfg_q.access_delays};
      REG_FLASH_UNLOCK: prdata = {63'd0, cfg_q.flash_unlock};
      default:          prdata = '0;
    endcase
  end

endmodule

[rtl/bmm_xlate.sv]
// address translation, access checks and unlock detector next state
module bmm_xlate (
  input  bmm_pkg::kind_e      kind_i,
  input  logic [21:0]         address_i,
  input  logic [7:0]          data_i,
  input  bmm_pkg::cfg_t       cfg_i,
  input  logic [2:0]          unlock_i,
  output logic [2:0]          unlock_o,
  output bmm_pkg::res_t       res_o
);
  import bmm_pkg::*;

  logic [15:0] la;
  logic [7:0]  bank_page;
  logic [15:0] top_lim;
  logic [15:0] bot_lim;
  logic        in_top;
  logic        in_bot;
  logic [7:0]  page;
  logic [21:0] phys;
  logic        in_flash;
  logic        in_ram;
  logic        in_sector;
  logic        locked;
  logic [21:0] masked;
  logic [2:0]  track;
  logic [7:0]  rpage;
  logic [13:0] roff;
  logic        rbot_hit;
  logic        rtop_hit;

  // forward mapping of the logical address
  assign la        = address_i[15:0];
  assign bank_page = cfg_i.page_map[{la[15:14], 3'b000} +: 8];
  assign top_lim   = LOGICAL_TOP - {4'd0, cfg_i.top_win, 6'd0};
  assign bot_lim   = UPPER_HALF + {4'd0, cfg_i.bot_win, 6'd0};
  assign in_top    = la[15] && (la > top_lim);
  assign in_bot    = la[15] && (la < bot_lim);
  assign page      = in_top ? TOP_PAGE : (in_bot ? BOTTOM_PAGE : bank_page);
  assign phys      = {page, la[13:0]};
  assign in_flash  = phys < FLASH_END;
  assign in_ram    = !in_flash && (phys < RAM_END);
  assign in_sector = (phys >= SECTOR_START) && in_flash;
  assign locked    = (page == LOCKED_PAGE) && !cfg_i.flash_unlock;
  assign masked    = phys & cfg_i.ram_exec_mask;

  // unlock sequence detector
  always_comb begin
    if (!in_sector) begin
      track = '0;
    end else if (unlock_i == UNLOCK_ARMED) begin
      track = UNLOCK_DONE;
    end else if (unlock_i < UNLOCK_ARMED && data_i == unlock_byte(unlock_i)) begin
      track = unlock_i + 3'd1;
    end else begin
      track = '0;
    end
  end

  // reverse lookup window hits
  assign rpage    = address_i[21:14];
  assign roff     = address_i[13:0];
  assign rbot_hit = roff < {2'd0, cfg_i.bot_win, 6'd0};
  assign rtop_hit = {1'b0, roff} >= (PAGE_SIZE - {3'd0, cfg_i.top_win, 6'd0});

  // result selection per transaction kind
  always_comb begin
    res_o                = '0;
    res_o.target         = TGT_NONE;
    res_o.restrict_fault = FLT_NONE;
    unlock_o             = unlock_i;
    case (kind_i)
      KIND_LOOKUP: begin
        res_o.phys_addr     = address_i;
        res_o.logical_valid = 1'b1;
        if (rpage == 8'd0) begin
          res_o.logical_addr = {2'b00, roff};
        end else if (rpage == cfg_i.page_map[15:8]) begin
          res_o.logical_addr = {2'b01, roff};
        end else if (rbot_hit ? (rpage == BOTTOM_PAGE) : (rpage == cfg_i.page_map[23:16])) begin
          res_o.logical_addr = {2'b10, roff};
        end else if (rtop_hit ? (rpage == TOP_PAGE) : (rpage == cfg_i.page_map[31:24])) begin
          res_o.logical_addr = {2'b11, roff};
        end else begin
          res_o.logical_valid = 1'b0;
        end
      end
      KIND_WRITE: begin
        res_o.phys_addr = phys;
        if (in_flash) begin
          res_o.target       = TGT_FLASH;
          res_o.cycles_added = cfg_i.access_delays[15:8];
        end else if (in_ram) begin
          res_o.target       = TGT_RAM;
          res_o.cycles_added = cfg_i.access_delays[39:32];
        end
      end
      KIND_READ, KIND_FETCH: begin
        res_o.phys_addr = phys;
        if (locked) begin
          res_o.target     = TGT_BLOCKED;
          res_o.read_value = EMPTY_BYTE;
        end else begin
          res_o.target = in_flash ? TGT_FLASH : (in_ram ? TGT_RAM : TGT_NONE);
          if (kind_i == KIND_READ) begin
            res_o.cycles_added = in_flash ? cfg_i.access_delays[7:0]
                                          : cfg_i.access_delays[31:24];
          end else if (in_flash) begin
            res_o.cycles_added = cfg_i.access_delays[23:16];
            if (page >= cfg_i.flash_exec_range[7:0] &&
                page <= cfg_i.flash_exec_range[15:8]) begin
              res_o.restrict_fault = FLT_FLASH;
            end
          end else begin
            res_o.cycles_added = cfg_i.access_delays[47:40];
            if (masked < cfg_i.ram_exec_bounds[21:0] ||
                masked > cfg_i.ram_exec_bounds[43:22]) begin
              res_o.restrict_fault = FLT_RAM;
            end
          end
          res_o.read_value  = data_i;
          unlock_o          = track;
          res_o.no_os_fault = (kind_i == KIND_FETCH) && (data_i == EMPTY_BYTE) &&
                              (la == RESET_VECTOR);
        end
      end
      default: ;
    endcase
    res_o.protect_state = unlock_o;
  end

endmodule
